// File: hdl/goal_heading_trajectory_cost_defines.svh
// Assertion macros shared by the goal heading cost block.
`ifndef GOAL_HEADING_TRAJECTORY_COST_DEFINES_SVH
`define GOAL_HEADING_TRAJECTORY_COST_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GHTC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ghtc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GHTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ghtc: next-cycle check failed");

`endif

// File: hdl/ghtc_pkg.sv
// Shared types, constants and width helpers of the goal heading cost block.
package ghtc_pkg;

	localparam int unsigned STEPS_DEFAULT = 64;

	localparam int unsigned ANGLE_W    = 16;
	localparam int unsigned COST_W     = 64;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned EXP_W      = 4;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_CRITIC_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GOAL_HEADING      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COST_WEIGHT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COST_EXPONENT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC_MODE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REMAINING_PATH    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATION_DIST   = 3'd6;

	// Register reset values.
	localparam logic [15:0]      RST_COST_WEIGHT     = 16'd768;
	localparam logic [EXP_W-1:0] RST_COST_EXPONENT   = 4'd1;
	localparam logic [15:0]      RST_ACTIVATION_DIST = 16'd500;

	localparam logic [ANGLE_W-1:0] HALF_TURN_FLIP = 16'h8000;

	// 2*pi in Q22, and the rounding offsets of the two product steps.
	localparam logic [63:0]  TWO_PI_Q22 = 64'd26353589;
	localparam logic [127:0] RND_BASE   = 128'd1 << 29;
	localparam logic [127:0] RND_Q24    = 128'd1 << 23;

	// Partial products per 64 x 64 multiplication on the 32 x 32 unit.
	localparam logic [2:0] MUL_PP = 3'd4;

	function automatic int unsigned count_width(int unsigned steps);
		return $clog2(steps + 1);
	endfunction

	function automatic int unsigned sum_width(int unsigned steps);
		return $clog2(steps * 32768 + 1);
	endfunction

	// Dividend is distance sum times Q8.8 weight times 256.
	function automatic int unsigned dividend_width(int unsigned steps);
		return sum_width(steps) + 24;
	endfunction

	typedef struct packed {
		logic       accept;
		logic       capture_prior;
		logic       prep;
		logic       clr_r;
		logic       div_step;
		logic       mv_start;
		logic       rv_start;
		logic       mul_step;
		logic       mul_acc;
		logic [1:0] pp_idx;
		logic       take_v;
		logic       take_r;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic             apply;
		logic [EXP_W-1:0] exponent;
		logic             out_busy;
	} sts_t;

endpackage

// File: hdl/ghtc_if.sv
// Valid/ready channel interfaces for sample words and cost words.
interface ghtc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] yaw_sample;
	logic        last_sample;
	logic [63:0] prior_cost;

	modport source (output valid, output yaw_sample, output last_sample, output prior_cost,
		input ready);
	modport sink (input valid, input yaw_sample, input last_sample, input prior_cost,
		output ready);
endinterface

interface ghtc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] updated_cost;

	modport source (output valid, output updated_cost, input ready);
	modport sink (input valid, input updated_cost, output ready);
endinterface

// File: hdl/goal_heading_trajectory_cost.sv
// Top level of the goal heading trajectory cost block.
//
// Yaw samples of one trajectory arrive as words on the samples channel, one sample
// per word; the word flagged last_sample also carries the prior cost. Each sample up
// to STEPS is folded into the distance accumulator in the cycle it is accepted, so
// samples that are not last are taken back to back at one word per cycle.
// The last sample starts the cost computation and holds ready low until the cost
// word is loaded into the output register. With the critic disabled or the path
// too long the prior cost passes straight through. Otherwise a serial divider of
// clog2(STEPS * 32768 + 1) + 24 bits forms the mean (46 at 64 steps), which is then
// scaled and raised to the configured power; each product step runs as four
// partial products on one 32 x 32 multiplier.
// The cost word waits in its own output register: a stalled receiver does not stop
// new samples of the next trajectory, only the next cost word from being loaded.
// Reset clears the accumulators, the controller and the output valid flag, and
// loads the register defaults. Configuration writes are taken at any edge with
// cfg_we high and are meant for when the block is idle.
`include "goal_heading_trajectory_cost_defines.svh"

module goal_heading_trajectory_cost #(
	parameter int unsigned STEPS = ghtc_pkg::STEPS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ghtc_in_if.sink                           samples,
	ghtc_out_if.source                        costs,
	input  logic                              cfg_we,
	input  logic [ghtc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ghtc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	ghtc_pkg::cmd_t cmd;
	ghtc_pkg::sts_t sts;
	logic           in_ready;

	assign samples.ready = in_ready;

	ghtc_ctrl #(
		.STEPS (STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_last  (samples.last_sample),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ghtc_dp #(
		.STEPS (STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.yaw_sample   (samples.yaw_sample),
		.prior_cost   (samples.prior_cost),
		.out_valid    (costs.valid),
		.out_ready    (costs.ready),
		.updated_cost (costs.updated_cost),
		.cmd          (cmd),
		.sts          (sts)
	);

	// A cost word is never loaded over one the receiver has not yet taken.
	`GHTC_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.finish, !sts.out_busy)
	// Accepting the last sample takes the controller out of its idle state.
	`GHTC_ASSERT_NEXT(a_busy_after_last, clk, arst_n, samples.valid && samples.ready && samples.last_sample, !samples.ready)
	// Loading the result makes it visible on the cost channel.
	`GHTC_ASSERT_NEXT(a_result_shown, clk, arst_n, cmd.finish, costs.valid)

endmodule

// File: hdl/ghtc_ctrl.sv
// Controller state machine sequencing accumulation, division and products.
module ghtc_ctrl #(
	parameter int unsigned STEPS = ghtc_pkg::STEPS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	output ghtc_pkg::cmd_t  cmd,
	input  ghtc_pkg::sts_t  sts
);

	localparam int unsigned DV_W = ghtc_pkg::dividend_width(STEPS);
	localparam int unsigned DC_W = $clog2(DV_W);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_VSTART,
		ST_VMUL,
		ST_VTAKE,
		ST_PSTART,
		ST_PMUL,
		ST_PTAKE,
		ST_FINISH
	} state_t;

	state_t                       state_q;
	logic [DC_W-1:0]              div_cnt_q;
	logic [2:0]                   mk_q;
	logic [ghtc_pkg::EXP_W-1:0]   pw_q;
	logic                         acc_in;

	assign in_ready = (state_q == ST_IDLE);
	assign acc_in   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
			mk_q      <= '0;
			pw_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in && in_last) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					div_cnt_q <= DC_W'(DV_W - 1);
					state_q   <= sts.apply ? ST_DIV : ST_FINISH;
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= ST_VSTART;
					end else begin
						div_cnt_q <= div_cnt_q - 1'b1;
					end
				end
				ST_VSTART: begin
					mk_q    <= '0;
					state_q <= ST_VMUL;
				end
				ST_VMUL: begin
					if (mk_q == ghtc_pkg::MUL_PP) begin
						state_q <= ST_VTAKE;
					end else begin
						mk_q <= mk_q + 1'b1;
					end
				end
				ST_VTAKE: begin
					if (sts.exponent > ghtc_pkg::EXP_W'(1)) begin
						pw_q    <= sts.exponent - 1'b1;
						state_q <= ST_PSTART;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_PSTART: begin
					mk_q    <= '0;
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					if (mk_q == ghtc_pkg::MUL_PP) begin
						state_q <= ST_PTAKE;
					end else begin
						mk_q <= mk_q + 1'b1;
					end
				end
				ST_PTAKE: begin
					if (pw_q == ghtc_pkg::EXP_W'(1)) begin
						state_q <= ST_FINISH;
					end else begin
						pw_q    <= pw_q - 1'b1;
						state_q <= ST_PSTART;
					end
				end
				ST_FINISH: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd               = '0;
		cmd.accept        = acc_in;
		cmd.capture_prior = acc_in && in_last;
		cmd.pp_idx        = mk_q[1:0];
		unique case (state_q) inside
			ST_PREP: begin
				cmd.prep  = 1'b1;
				cmd.clr_r = !sts.apply;
			end
			ST_DIV:    cmd.div_step = 1'b1;
			ST_VSTART: cmd.mv_start = 1'b1;
			ST_PSTART: cmd.rv_start = 1'b1;
			ST_VMUL, ST_PMUL: begin
				cmd.mul_step = (mk_q != ghtc_pkg::MUL_PP);
				cmd.mul_acc  = (mk_q != '0);
			end
			ST_VTAKE:  cmd.take_v = 1'b1;
			ST_PTAKE:  cmd.take_r = 1'b1;
			ST_FINISH: cmd.finish = !sts.out_busy;
			default: begin
			end
		endcase
	end

endmodule

// File: hdl/ghtc_dp.sv
// Datapath: registers, distance accumulator, serial divider and product unit.
module ghtc_dp #(
	parameter int unsigned STEPS = ghtc_pkg::STEPS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ghtc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ghtc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [ghtc_pkg::ANGLE_W-1:0]      yaw_sample,
	input  logic [ghtc_pkg::COST_W-1:0]       prior_cost,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ghtc_pkg::COST_W-1:0]       updated_cost,
	input  ghtc_pkg::cmd_t                    cmd,
	output ghtc_pkg::sts_t                    sts
);

	localparam int unsigned CNT_W = ghtc_pkg::count_width(STEPS);
	localparam int unsigned SUM_W = ghtc_pkg::sum_width(STEPS);
	localparam int unsigned SW_W  = SUM_W + 16;
	localparam int unsigned DV_W  = ghtc_pkg::dividend_width(STEPS);

	// Configuration registers.
	logic                         enable_q;
	logic [15:0]                  goal_q;
	logic [15:0]                  weight_q;
	logic [ghtc_pkg::EXP_W-1:0]   exp_q;
	logic                         sym_q;
	logic [15:0]                  path_q;
	logic [15:0]                  act_q;

	// Accumulators.
	logic [SUM_W-1:0]             sum_q;
	logic [CNT_W-1:0]             cnt_q;

	// Divider, product unit and result registers.
	logic [DV_W-1:0]              dvd_q;
	logic [CNT_W-1:0]             rem_q;
	logic [CNT_W-1:0]             div_q;
	logic [63:0]                  a_q;
	logic [63:0]                  b_q;
	logic [127:0]                 acc_q;
	logic [63:0]                  pp_s1;
	logic [1:0]                   pp_sh_s1;
	logic [63:0]                  v_q;
	logic [63:0]                  r_q;
	logic [63:0]                  prior_q;
	logic                         out_valid_q;
	logic [63:0]                  out_data_q;

	logic [15:0]                  diff;
	logic [15:0]                  diff_opp;
	logic [15:0]                  d_goal;
	logic [15:0]                  d_opp;
	logic [15:0]                  d_min;
	logic [SW_W-1:0]              sw;
	logic [CNT_W:0]               trial;
	logic [CNT_W:0]               trial_sub;
	logic                         qbit;
	logic [31:0]                  a_seg;
	logic [31:0]                  b_seg;
	logic [127:0]                 pp_shifted;
	logic [64:0]                  final_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			goal_q   <= '0;
			weight_q <= ghtc_pkg::RST_COST_WEIGHT;
			exp_q    <= ghtc_pkg::RST_COST_EXPONENT;
			sym_q    <= 1'b0;
			path_q   <= '0;
			act_q    <= ghtc_pkg::RST_ACTIVATION_DIST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ghtc_pkg::CFG_CRITIC_ENABLE:   enable_q <= cfg_data[0];
				ghtc_pkg::CFG_GOAL_HEADING:    goal_q   <= cfg_data;
				ghtc_pkg::CFG_COST_WEIGHT:     weight_q <= cfg_data;
				ghtc_pkg::CFG_COST_EXPONENT:   exp_q    <= cfg_data[ghtc_pkg::EXP_W-1:0];
				ghtc_pkg::CFG_SYMMETRIC_MODE:  sym_q    <= cfg_data[0];
				ghtc_pkg::CFG_REMAINING_PATH:  path_q   <= cfg_data;
				ghtc_pkg::CFG_ACTIVATION_DIST: act_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Shortest wrapped distance; the opposite heading differs only in the top bit.
	always_comb begin
		diff     = yaw_sample - goal_q;
		diff_opp = diff ^ ghtc_pkg::HALF_TURN_FLIP;
		d_goal   = diff[15] ? (16'd0 - diff) : diff;
		d_opp    = diff_opp[15] ? (16'd0 - diff_opp) : diff_opp;
		d_min    = (sym_q && (d_opp < d_goal)) ? d_opp : d_goal;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.prep) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.accept && (cnt_q < CNT_W'(STEPS))) begin
			sum_q <= sum_q + SUM_W'(d_min);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign sw        = SW_W'(sum_q) * SW_W'(weight_q);
	assign trial     = {rem_q, dvd_q[DV_W-1]};
	assign trial_sub = trial - {1'b0, div_q};
	assign qbit      = (trial >= {1'b0, div_q});

	assign a_seg = cmd.pp_idx[0] ? a_q[63:32] : a_q[31:0];
	assign b_seg = cmd.pp_idx[1] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (pp_sh_s1)
			2'd0:    pp_shifted = {64'd0, pp_s1};
			2'd1:    pp_shifted = {32'd0, pp_s1, 32'd0};
			2'd2:    pp_shifted = {pp_s1, 64'd0};
			default: pp_shifted = '0;
		endcase
	end

	assign final_sum = {1'b0, prior_q} + {1'b0, r_q};

	always_ff @(posedge clk) begin
		if (cmd.capture_prior) begin
			prior_q <= prior_cost;
		end
		if (cmd.prep) begin
			dvd_q <= {sw, 8'd0};
			rem_q <= '0;
			div_q <= (cnt_q == '0) ? CNT_W'(1) : cnt_q;
		end else if (cmd.div_step) begin
			rem_q <= qbit ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[DV_W-2:0], qbit};
		end
		if (cmd.mv_start) begin
			a_q   <= 64'(dvd_q);
			b_q   <= ghtc_pkg::TWO_PI_Q22;
			acc_q <= ghtc_pkg::RND_BASE;
		end else if (cmd.rv_start) begin
			a_q   <= r_q;
			b_q   <= v_q;
			acc_q <= ghtc_pkg::RND_Q24;
		end else if (cmd.mul_acc) begin
			acc_q <= acc_q + pp_shifted;
		end
		if (cmd.mul_step) begin
			pp_s1    <= 64'(a_seg) * 64'(b_seg);
			pp_sh_s1 <= {1'b0, cmd.pp_idx[0]} + {1'b0, cmd.pp_idx[1]};
		end
		if (cmd.clr_r) begin
			r_q <= '0;
		end else if (cmd.take_v) begin
			v_q <= acc_q[93:30];
			r_q <= acc_q[93:30];
		end else if (cmd.take_r) begin
			r_q <= (|acc_q[127:88]) ? '1 : acc_q[87:24];
		end
		if (cmd.finish) begin
			out_data_q <= final_sum[64] ? '1 : final_sum[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign updated_cost = out_data_q;

	assign sts.apply    = enable_q && (path_q <= act_q);
	assign sts.exponent = exp_q;
	assign sts.out_busy = out_valid_q && !out_ready;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench of the goal heading trajectory cost block.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned STEPS           = 64;
	// Half a turn in binary-angle units, and 2*pi in Q22 for the radian scaling.
	localparam logic [15:0] HALF_TURN       = 16'h8000;
	localparam logic [63:0] TWO_PI_Q22      = 64'd26353589;
	localparam int unsigned PHASES          = 8;
	localparam int unsigned WORDS_PER_PHASE = 225;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	// A sample that is not last is folded in the cycle it is taken, so a short pause
	// after the final cost word is enough before the registers are touched.
	localparam int unsigned SETTLE_CYCLES   = 8;
	// Worst cost computation is the one at power fifteen.
	localparam int unsigned TAIL_CYCLES     = 200;
	localparam int unsigned DRAIN_LIMIT     = 50000;
	localparam int unsigned CYCLE_LIMIT     = 1000000;

	typedef enum logic {ROW_WORD, ROW_WRITE} row_kind_t;

	// One row of the directed plan: either a sample word or a register write.
	// Where known is set, want is the cost word read straight off the arithmetic.
	typedef struct packed {
		row_kind_t                        kind;
		logic [ghtc_pkg::CFG_IDX_W-1:0]   index;
		logic [15:0]                      value;
		logic                             last;
		logic [63:0]                      prior;
		logic                             known;
		logic [63:0]                      want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [ghtc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ghtc_pkg::CFG_DATA_W-1:0] cfg_data;

	ghtc_in_if  sample_bus ();
	ghtc_out_if cost_bus ();

	goal_heading_trajectory_cost #(.STEPS(STEPS)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_bus),
		.costs     (cost_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the register file, at the widths the block keeps.
	logic        reg_enable;
	logic [15:0] reg_goal;
	logic [15:0] reg_weight;
	logic [3:0]  reg_exponent;
	logic        reg_symmetric;
	logic [15:0] reg_path_mm;
	logic [15:0] reg_activation_mm;

	// Mirror of the trajectory accumulators.
	logic [25:0] sum_gap;
	logic [10:0] gap_count;

	logic [63:0] pending_costs[$];
	plan_row_t   plan[$];

	int unsigned mismatches    = 0;
	int unsigned cycle_count   = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	bit          hold_off_req  = 1'b0;

	// ------------------------------------------------------------------
	// Cost prediction
	// ------------------------------------------------------------------

	// Shortest unsigned distance between two binary angles; exactly half a turn
	// stays at 32768.
	function automatic logic [15:0] angle_gap(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] diff;
		diff = a - b;
		return diff[15] ? 16'(17'h10000 - {1'b0, diff}) : diff;
	endfunction

	// Q.24 product with round half up, pinned at all ones when it overflows.
	function automatic logic [63:0] q24_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] full;
		full = {64'd0, a} * {64'd0, b} + (128'd1 << 23);
		if (full[127:88] != '0)
			return '1;
		return full[87:24];
	endfunction

	// Mean distance in radians, times the weight, raised to the configured power.
	function automatic logic [63:0] heading_cost_q24(input logic [25:0] sum,
			input logic [10:0] count);
		logic [127:0] mean_scaled;
		logic [127:0] base;
		logic [63:0]  unit;
		logic [63:0]  acc;
		mean_scaled = (128'(sum) * 128'(reg_weight) * 128'd256) /
			128'((count == '0) ? 11'd1 : count);
		base = (mean_scaled * 128'(TWO_PI_Q22) + (128'd1 << 29)) >> 30;
		unit = base[63:0];
		acc = unit;
		for (int k = 1; k < int'(reg_exponent); k++)
			acc = q24_product(acc, unit);
		return acc;
	endfunction

	// Folds one accepted sample into the accumulators. Returns 1 with the cost word
	// when the sample closes the trajectory.
	function automatic bit fold_sample(input logic [15:0] yaw, input logic last,
			input logic [63:0] prior, output logic [63:0] cost);
		logic [15:0] gap;
		logic [15:0] gap_flip;
		logic [64:0] total;
		gap = angle_gap(yaw, reg_goal);
		if (reg_symmetric) begin
			gap_flip = angle_gap(yaw, reg_goal + HALF_TURN);
			if (gap_flip < gap)
				gap = gap_flip;
		end
		// Samples beyond the step budget are dropped until the trajectory closes.
		if (gap_count < STEPS) begin
			sum_gap += 26'(gap);
			gap_count++;
		end
		cost = prior;
		if (!last)
			return 1'b0;
		if (reg_enable && reg_path_mm <= reg_activation_mm) begin
			total = {1'b0, prior} + {1'b0, heading_cost_q24(sum_gap, gap_count)};
			cost = total[64] ? '1 : total[63:0];
		end
		sum_gap = '0;
		gap_count = '0;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offers one sample word; the cost expectation is queued at the edge that takes
	// it. Entered and left at a falling edge.
	task automatic push_word(input logic [15:0] yaw, input logic last, input logic [63:0] prior,
			input logic known, input logic [63:0] want);
		logic [63:0] cost;
		while ($urandom_range(99) < send_idle_pct) begin
			sample_bus.valid = 1'b0;
			@(negedge clk);
		end
		sample_bus.valid       = 1'b1;
		sample_bus.yaw_sample  = yaw;
		sample_bus.last_sample = last;
		sample_bus.prior_cost  = prior;
		do
			@(posedge clk);
		while (!sample_bus.ready);
		if (fold_sample(yaw, last, prior, cost))
			pending_costs.push_back(known ? want : cost);
		@(negedge clk);
		sample_bus.valid = 1'b0;
	endtask

	// Holds the sender back until every cost word owed has come out.
	task automatic drain_costs();
		sample_bus.valid = 1'b0;
		while (pending_costs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write on the configuration port; only called with the block idle.
	task automatic write_reg(input logic [ghtc_pkg::CFG_IDX_W-1:0] index,
			input logic [15:0] value);
		cfg_we    = 1'b1;
		cfg_index = index;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (index)
			ghtc_pkg::CFG_CRITIC_ENABLE:   reg_enable        = value[0];
			ghtc_pkg::CFG_GOAL_HEADING:    reg_goal          = value;
			ghtc_pkg::CFG_COST_WEIGHT:     reg_weight        = value;
			ghtc_pkg::CFG_COST_EXPONENT:   reg_exponent      = value[3:0];
			ghtc_pkg::CFG_SYMMETRIC_MODE:  reg_symmetric     = value[0];
			ghtc_pkg::CFG_REMAINING_PATH:  reg_path_mm       = value;
			ghtc_pkg::CFG_ACTIVATION_DIST: reg_activation_mm = value;
			default: ;
		endcase
	endtask

	function automatic plan_row_t word_row(input logic [15:0] yaw, input logic last,
			input logic [63:0] prior, input logic known, input logic [63:0] want);
		plan_row_t row;
		row       = '0;
		row.kind  = ROW_WORD;
		row.value = yaw;
		row.last  = last;
		row.prior = prior;
		row.known = known;
		row.want  = want;
		return row;
	endfunction

	function automatic plan_row_t write_row(input logic [ghtc_pkg::CFG_IDX_W-1:0] index,
			input logic [15:0] value);
		plan_row_t row;
		row       = '0;
		row.kind  = ROW_WRITE;
		row.index = index;
		row.value = value;
		return row;
	endfunction

	// ------------------------------------------------------------------
	// Random content
	// ------------------------------------------------------------------

	// Mostly short trajectories, some medium, and a few long ones that can overrun the step budget.
	function automatic int unsigned pick_length();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return $urandom_range(1, 8);
		if (roll < 92)
			return $urandom_range(9, 40);
		return $urandom_range(60, 80);
	endfunction

	// Headings cluster round the goal and its opposite so that the symmetric choice
	// and the wrap at half a turn are hit often; others sit a quarter turn off or anywhere.
	function automatic logic [15:0] pick_yaw();
		logic [15:0] jitter;
		jitter = 16'($urandom_range(512)) - 16'd256;
		case ($urandom_range(5))
			0: return 16'($urandom);
			1: return reg_goal + jitter;
			2: return reg_goal + HALF_TURN + jitter;
			3: return reg_goal + HALF_TURN;
			4: return reg_goal + 16'h4000 + jitter;
			default: return reg_goal;
		endcase
	endfunction

	function automatic logic [63:0] pick_prior();
		case ($urandom_range(3))
			0: return '1 - 64'($urandom_range(1 << 20));
			1: return 64'($urandom_range(65535));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// New register settings for a phase; a few phases pin the extremes.
	task automatic configure_phase(input int unsigned phase);
		logic [15:0] activation;
		logic [15:0] path;
		logic [15:0] weight;
		logic [3:0]  power;
		drain_costs();
		case (phase)
			2: activation = 16'd0;
			7: activation = 16'hFFFF;
			default: activation = 16'($urandom);
		endcase
		if (phase == 7)
			path = 16'hFFFF;
		else if ($urandom_range(5) == 0)
			path = 16'($urandom);
		else
			path = 16'($urandom_range(activation));
		case (phase)
			3: weight = 16'hFFFF;
			6: weight = 16'd0;
			default: weight = ($urandom_range(3) == 0) ? 16'($urandom_range(192, 320))
				: 16'($urandom);
		endcase
		case (phase)
			3: power = 4'd15;
			5: power = 4'd8;
			6: power = 4'd0;
			default: power = ($urandom_range(4) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(8));
		endcase
		write_reg(ghtc_pkg::CFG_CRITIC_ENABLE, 16'($urandom_range(7) != 0));
		write_reg(ghtc_pkg::CFG_GOAL_HEADING, (phase == 0) ? 16'hFFFF : 16'($urandom));
		write_reg(ghtc_pkg::CFG_COST_WEIGHT, weight);
		write_reg(ghtc_pkg::CFG_COST_EXPONENT, 16'(power));
		write_reg(ghtc_pkg::CFG_SYMMETRIC_MODE, 16'(phase[0]));
		write_reg(ghtc_pkg::CFG_ACTIVATION_DIST, activation);
		write_reg(ghtc_pkg::CFG_REMAINING_PATH, path);
	endtask

	// ------------------------------------------------------------------
	// Receiver side
	// ------------------------------------------------------------------

	// Ready is chosen at each falling edge. A hold-off request keeps it low for a
	// long stretch so that the output register fills and the sample side backs up.
	always begin
		@(negedge clk);
		if (hold_off_req) begin
			cost_bus.ready = 1'b0;
			for (int n = 0; n < HOLD_OFF_CYCLES; n++)
				@(negedge clk);
			hold_off_req = 1'b0;
		end
		cost_bus.ready = ($urandom_range(99) >= stall_pct);
	end

	// Every cost word taken is matched against the oldest expectation.
	always @(posedge clk) begin : check_costs
		logic [63:0] want;
		if (arst_n && cost_bus.valid && cost_bus.ready) begin
			if (pending_costs.size() == 0) begin
				$error("updated_cost: no expected word waiting, got %h",
					cost_bus.updated_cost);
				mismatches++;
			end else begin
				want = pending_costs.pop_front();
				if (cost_bus.updated_cost !== want) begin
					$error("updated_cost: expected %h, got %h", want, cost_bus.updated_cost);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	initial begin : stimulus
		int unsigned phase_words;
		int unsigned len;
		bit          paused;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = ghtc_pkg::CFG_CRITIC_ENABLE;
		cfg_data               = '0;
		sample_bus.valid       = 1'b0;
		sample_bus.yaw_sample  = '0;
		sample_bus.last_sample = 1'b0;
		sample_bus.prior_cost  = '0;
		cost_bus.ready         = 1'b0;

		reg_enable        = 1'b1;
		reg_goal          = '0;
		reg_weight        = 16'd768;
		reg_exponent      = 4'd1;
		reg_symmetric     = 1'b0;
		reg_path_mm       = '0;
		reg_activation_mm = 16'd500;
		sum_gap           = '0;
		gap_count         = '0;

		// Directed plan. With the reset weight of 3.0 a heading on the goal costs
		// nothing and one half a turn away costs exactly 3*pi, which is 6 * TWO_PI_Q22.
		plan.push_back(word_row(16'h0000, 1'b1, 64'd0, 1'b1, 64'd0));
		plan.push_back(word_row(16'h8000, 1'b1, 64'd0, 1'b1, 64'd158121534));
		plan.push_back(word_row(16'hFFFF, 1'b0, 64'hFFFF_FFFF_0000_0000, 1'b0, '0));
		plan.push_back(word_row(16'h0001, 1'b1, 64'h0000_0001_0000_0000, 1'b0, '0));
		// A full prior cost plus anything non-zero pins at the top.
		plan.push_back(word_row(16'h8000, 1'b1, '1, 1'b1, '1));
		// Critic off: the prior cost passes straight through.
		plan.push_back(write_row(ghtc_pkg::CFG_CRITIC_ENABLE, 16'd0));
		plan.push_back(word_row(16'h1234, 1'b1, 64'h0123_4567_89AB_CDEF,
			1'b1, 64'h0123_4567_89AB_CDEF));
		plan.push_back(write_row(ghtc_pkg::CFG_CRITIC_ENABLE, 16'd1));
		// Path one millimetre too long, then exactly at the activation distance.
		plan.push_back(write_row(ghtc_pkg::CFG_REMAINING_PATH, 16'd501));
		plan.push_back(word_row(16'h4000, 1'b1, 64'd42, 1'b1, 64'd42));
		plan.push_back(write_row(ghtc_pkg::CFG_REMAINING_PATH, 16'd500));
		plan.push_back(word_row(16'h4000, 1'b1, 64'd42, 1'b0, '0));
		plan.push_back(write_row(ghtc_pkg::CFG_ACTIVATION_DIST, 16'd0));
		plan.push_back(word_row(16'h4000, 1'b1, 64'd42, 1'b1, 64'd42));
		plan.push_back(write_row(ghtc_pkg::CFG_REMAINING_PATH, 16'd0));
		plan.push_back(word_row(16'h7FFF, 1'b1, 64'd0, 1'b0, '0));
		// Symmetric mode: the heading opposite the goal counts as on target.
		plan.push_back(write_row(ghtc_pkg::CFG_GOAL_HEADING, 16'h4000));
		plan.push_back(write_row(ghtc_pkg::CFG_SYMMETRIC_MODE, 16'd1));
		plan.push_back(word_row(16'hC000, 1'b0, 64'd0, 1'b0, '0));
		plan.push_back(word_row(16'h0000, 1'b0, 64'd0, 1'b0, '0));
		plan.push_back(word_row(16'h4001, 1'b0, 64'd0, 1'b0, '0));
		plan.push_back(word_row(16'hBFFF, 1'b1, 64'd7, 1'b0, '0));
		plan.push_back(write_row(ghtc_pkg::CFG_SYMMETRIC_MODE, 16'd0));
		plan.push_back(word_row(16'hC000, 1'b1, 64'd0, 1'b1, 64'd158121534));
		// Power zero is linear; power two squares; power fifteen at full weight
		// overflows and pins at the top.
		plan.push_back(write_row(ghtc_pkg::CFG_COST_EXPONENT, 16'd0));
		plan.push_back(word_row(16'h5000, 1'b1, 64'd100, 1'b0, '0));
		plan.push_back(write_row(ghtc_pkg::CFG_COST_EXPONENT, 16'd2));
		plan.push_back(word_row(16'h6000, 1'b1, 64'd0, 1'b0, '0));
		plan.push_back(write_row(ghtc_pkg::CFG_COST_WEIGHT, 16'hFFFF));
		plan.push_back(write_row(ghtc_pkg::CFG_COST_EXPONENT, 16'd15));
		plan.push_back(word_row(16'hC000, 1'b1, 64'd0, 1'b1, '1));
		// Zero weight adds nothing whatever the heading.
		plan.push_back(write_row(ghtc_pkg::CFG_COST_WEIGHT, 16'd0));
		plan.push_back(word_row(16'h1111, 1'b0, 64'd0, 1'b0, '0));
		plan.push_back(word_row(16'h9999, 1'b1, 64'h8000_0000_0000_0001,
			1'b1, 64'h8000_0000_0000_0001));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 29;
		stall_pct     = 29;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				drain_costs();
				write_reg(plan[i].index, plan[i].value);
			end else begin
				push_word(plan[i].value, plan[i].last, plan[i].prior,
					plan[i].known, plan[i].want);
			end
		end

		// Random phases, cycling through the idling patterns: none, sender idle,
		// receiver stalling, both. Registers change only between whole trajectories.
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			configure_phase(phase);
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 66;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 66;
				end
				default: begin
					send_idle_pct = 29;
					stall_pct     = 29;
				end
			endcase
			// Receiver blocks for a long stretch while samples keep streaming in.
			if (phase == 4)
				hold_off_req = 1'b1;
			phase_words = 0;
			paused = 1'b0;
			while (phase_words < WORDS_PER_PHASE) begin
				len = pick_length();
				for (int unsigned k = 1; k <= len; k++)
					push_word(pick_yaw(), k == len, pick_prior(), 1'b0, '0);
				phase_words += len;
				// In phase 1 the sender waits half way through for every owed cost word.
				if (phase == 1 && !paused && phase_words >= WORDS_PER_PHASE / 2) begin
					drain_costs();
					paused = 1'b1;
				end
			end
		end

		sample_bus.valid = 1'b0;
		for (int unsigned w = 0; w < DRAIN_LIMIT && pending_costs.size() != 0; w++)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_costs.size() != 0) begin
			$error("updated_cost: %0d expected words never arrived", pending_costs.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
